// ----- hw/rtl/kmst_pkg.sv -----
// kmst_pkg: shared types and constants for the key matrix state tracker
// used by kmst_ctrl, kmst_datapath and key_matrix_state_tracker; no dependencies
package kmst_pkg;

    localparam int ROW_COUNT   = 4;
    localparam int COL_COUNT   = 12;
    localparam int SAMPLE_ROWS = 4;
    localparam int KIND_W      = 3;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 5;

    typedef enum logic [KIND_W-1:0] {
        OP_BEGIN        = 3'd0,
        OP_SAMPLE       = 3'd1,
        OP_END          = 3'd2,
        OP_QUERY        = 3'd3,
        OP_SUPPRESS_ALL = 3'd4,
        OP_SUPPRESS_KEY = 3'd5,
        OP_MARK         = 3'd6,
        OP_UNMARK       = 3'd7
    } op_t;

    typedef struct packed {
        logic load;
        logic exec;
        op_t  op;
    } cmd_t;

endpackage

// ----- hw/rtl/kmst_ctrl.sv -----
// kmst_ctrl: controller state machine, takes a word and sequences its execution
// depends on kmst_pkg
module kmst_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [kmst_pkg::KIND_W-1:0] kind,
    output logic                       busy,
    output logic                       done,
    output kmst_pkg::cmd_t             cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t        state_reg;
    kmst_pkg::op_t op_reg;
    logic          done_reg;
    logic          accept;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg == ST_EXEC);
    assign done     = done_reg;
    assign cmd.load = accept;
    assign cmd.exec = (state_reg == ST_EXEC);
    assign cmd.op   = op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= kmst_pkg::OP_BEGIN;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= kmst_pkg::op_t'(kind);
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted word did not enter execution");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> done_reg)
        else $error("execution did not produce a result strobe");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while still busy");

endmodule

// ----- hw/rtl/kmst_datapath.sv -----
// kmst_datapath: per-row key state words, item operand latch and result registers
// depends on kmst_pkg; driven by kmst_ctrl commands
module kmst_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kmst_pkg::cmd_t              cmd,
    input  logic [kmst_pkg::ROW_W-1:0]  key_row,
    input  logic [kmst_pkg::COL_W-1:0]  key_col,
    input  logic [kmst_pkg::SAMPLE_ROWS-1:0] row_bits,
    input  logic                        include_handled,
    output logic                        key_down,
    output logic                        key_went_down,
    output logic                        key_went_up,
    output logic                        scan_complete
);

    localparam int RC = kmst_pkg::ROW_COUNT;
    localparam int CC = kmst_pkg::COL_COUNT;

    logic [CC-1:0] prev_reg    [RC];
    logic [CC-1:0] cur_reg     [RC];
    logic [CC-1:0] handled_reg [RC];
    logic [CC-1:0] press_reg   [RC];
    logic [CC-1:0] release_reg [RC];
    logic [CC-1:0] supp_reg    [RC];

    logic [CC-1:0] prev_next    [RC];
    logic [CC-1:0] cur_next     [RC];
    logic [CC-1:0] handled_next [RC];
    logic [CC-1:0] press_next   [RC];
    logic [CC-1:0] release_next [RC];
    logic [CC-1:0] supp_next    [RC];

    logic [kmst_pkg::ROW_W-1:0]       row_reg;
    logic [kmst_pkg::COL_W-1:0]       col_reg;
    logic [kmst_pkg::SAMPLE_ROWS-1:0] bits_reg;
    logic                             incl_reg;

    logic key_down_reg, went_down_reg, went_up_reg, scan_complete_reg;
    logic key_down_next, went_down_next, went_up_next, scan_complete_next;

    logic                                col_ok;
    logic                                key_ok;
    logic [CC-1:0]                       col_bit;
    logic [RC-1:0]                       row_hit;
    logic [RC+kmst_pkg::SAMPLE_ROWS-1:0] bits_ext;

    // rows beyond the sampled ones are never set
    assign bits_ext = {{RC{1'b0}}, bits_reg};
    assign col_ok   = ({1'b0, col_reg} < (kmst_pkg::COL_W + 1)'(CC));
    assign key_ok   = col_ok && ({1'b0, row_reg} < (kmst_pkg::ROW_W + 1)'(RC));
    assign col_bit  = col_ok ? (CC'(1) << col_reg) : '0;

    always_comb
    begin
        for (int r = 0; r < RC; r++)
        begin
            row_hit[r] = key_ok && (row_reg == kmst_pkg::ROW_W'(r));
        end
    end

    always_comb
    begin
        logic [CC-1:0] w;
        w = '0;
        key_down_next      = 1'b0;
        went_down_next     = 1'b0;
        went_up_next       = 1'b0;
        scan_complete_next = 1'b0;
        for (int r = 0; r < RC; r++)
        begin
            prev_next[r]    = prev_reg[r];
            cur_next[r]     = cur_reg[r];
            handled_next[r] = handled_reg[r];
            press_next[r]   = press_reg[r];
            release_next[r] = release_reg[r];
            supp_next[r]    = supp_reg[r];
        end
        if (cmd.exec)
        begin
            case (cmd.op)
                kmst_pkg::OP_BEGIN:
                begin
                    for (int r = 0; r < RC; r++)
                    begin
                        prev_next[r]    = cur_reg[r];
                        cur_next[r]     = '0;
                        handled_next[r] = '0;
                        press_next[r]   = '0;
                        release_next[r] = '0;
                    end
                end
                kmst_pkg::OP_SAMPLE:
                begin
                    for (int r = 0; r < RC; r++)
                    begin
                        if (bits_ext[r])
                        begin
                            cur_next[r] = cur_reg[r] | col_bit;
                        end
                    end
                end
                kmst_pkg::OP_END:
                begin
                    for (int r = 0; r < RC; r++)
                    begin
                        press_next[r]   = cur_reg[r] & ~prev_reg[r];
                        release_next[r] = prev_reg[r] & ~cur_reg[r];
                        supp_next[r]    = supp_reg[r] & ~(prev_reg[r] & ~cur_reg[r]);
                    end
                    scan_complete_next = 1'b1;
                end
                kmst_pkg::OP_QUERY:
                begin
                    for (int r = 0; r < RC; r++)
                    begin
                        if (row_hit[r])
                        begin
                            w = cur_reg[r] & ~supp_reg[r];
                            if (!incl_reg)
                            begin
                                w = w & ~handled_reg[r];
                            end
                            key_down_next  = |(w & col_bit);
                            went_down_next = |(press_reg[r] & col_bit);
                            went_up_next   = |(release_reg[r] & col_bit);
                        end
                    end
                end
                kmst_pkg::OP_SUPPRESS_ALL:
                begin
                    for (int r = 0; r < RC; r++)
                    begin
                        supp_next[r] = supp_reg[r] | cur_reg[r];
                    end
                end
                kmst_pkg::OP_SUPPRESS_KEY:
                begin
                    for (int r = 0; r < RC; r++)
                    begin
                        if (row_hit[r])
                        begin
                            supp_next[r] = supp_reg[r] | (cur_reg[r] & col_bit);
                        end
                    end
                end
                kmst_pkg::OP_MARK:
                begin
                    for (int r = 0; r < RC; r++)
                    begin
                        if (row_hit[r])
                        begin
                            handled_next[r] = handled_reg[r] | col_bit;
                        end
                    end
                end
                kmst_pkg::OP_UNMARK:
                begin
                    for (int r = 0; r < RC; r++)
                    begin
                        if (row_hit[r])
                        begin
                            handled_next[r] = handled_reg[r] & ~col_bit;
                        end
                    end
                end
                default:
                begin
                    scan_complete_next = 1'b0;
                end
            endcase
        end
    end

    // operand latch for the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_reg  <= key_row;
            col_reg  <= key_col;
            bits_reg <= row_bits;
            incl_reg <= include_handled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < RC; r++)
            begin
                prev_reg[r]    <= '0;
                cur_reg[r]     <= '0;
                handled_reg[r] <= '0;
                press_reg[r]   <= '0;
                release_reg[r] <= '0;
                supp_reg[r]    <= '0;
            end
            key_down_reg      <= 1'b0;
            went_down_reg     <= 1'b0;
            went_up_reg       <= 1'b0;
            scan_complete_reg <= 1'b0;
        end
        else
        begin
            for (int r = 0; r < RC; r++)
            begin
                prev_reg[r]    <= prev_next[r];
                cur_reg[r]     <= cur_next[r];
                handled_reg[r] <= handled_next[r];
                press_reg[r]   <= press_next[r];
                release_reg[r] <= release_next[r];
                supp_reg[r]    <= supp_next[r];
            end
            if (cmd.exec)
            begin
                key_down_reg      <= key_down_next;
                went_down_reg     <= went_down_next;
                went_up_reg       <= went_up_next;
                scan_complete_reg <= scan_complete_next;
            end
        end
    end

    assign key_down      = key_down_reg;
    assign key_went_down = went_down_reg;
    assign key_went_up   = went_up_reg;
    assign scan_complete = scan_complete_reg;

    a_scan_no_query: assert property (@(posedge clk) disable iff (!rst_n)
        scan_complete_reg |-> !(key_down_reg || went_down_reg || went_up_reg))
        else $error("end-scan result carries query bits");

    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (press_reg[0] & release_reg[0]) == '0)
        else $error("key both pressed and released in one scan");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> ($stable(cur_reg[0]) && $stable(supp_reg[0])))
        else $error("key state changed without an executing word");

endmodule

// ----- hw/rtl/key_matrix_state_tracker.sv -----
// key_matrix_state_tracker: top level, joins controller and datapath
// depends on kmst_pkg, kmst_ctrl, kmst_datapath
// result strobe done is registered: set as the execute state returns to idle
// a new word is accepted only when idle; busy is high for the execute cycle
// the execute cycle updates all key words at once and loads the result registers
// reset clears every key word and the controller; the receiver cannot stall
module key_matrix_state_tracker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [kmst_pkg::KIND_W-1:0]      kind,
    input  logic [kmst_pkg::ROW_W-1:0]       key_row,
    input  logic [kmst_pkg::COL_W-1:0]       key_col,
    input  logic [kmst_pkg::SAMPLE_ROWS-1:0] row_bits,
    input  logic                             include_handled,
    output logic                             done,
    output logic                             key_down,
    output logic                             key_went_down,
    output logic                             key_went_up,
    output logic                             scan_complete
);

    kmst_pkg::cmd_t cmd;

    kmst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    kmst_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .key_row         (key_row),
        .key_col         (key_col),
        .row_bits        (row_bits),
        .include_handled (include_handled),
        .key_down        (key_down),
        .key_went_down   (key_went_down),
        .key_went_up     (key_went_up),
        .scan_complete   (scan_complete)
    );

endmodule
